@@ sv/gmma_pkg.sv @@
// Shared types, constants and the control program of the gaze mapping block.
package gmma_pkg;

    // Fixed field widths.
    localparam int PIX_W     = 12;
    localparam int CAL_W     = 12;
    localparam int SCR_W     = 13;
    localparam int OUT_W     = 21;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAL_LEFT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TOP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_RIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_BOTTOM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

    // Register values after reset.
    localparam logic [CAL_W-1:0] RST_CAL_LEFT      = 12'd0;
    localparam logic [CAL_W-1:0] RST_CAL_TOP       = 12'd0;
    localparam logic [CAL_W-1:0] RST_CAL_RIGHT     = 12'd639;
    localparam logic [CAL_W-1:0] RST_CAL_BOTTOM    = 12'd479;
    localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = 13'd1920;
    localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = 13'd1080;

    // Microprogram step address.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    // Datapath operations.
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP     = 4'd0;
    localparam t_op OP_DIFF    = 4'd1;
    localparam t_op OP_MUL     = 4'd2;
    localparam t_op OP_DIV_MAP = 4'd3;
    localparam t_op OP_RES     = 4'd4;
    localparam t_op OP_RD      = 4'd5;
    localparam t_op OP_ACC     = 4'd6;
    localparam t_op OP_DIV_AVG = 4'd7;
    localparam t_op OP_ZERO    = 4'd8;
    localparam t_op OP_OUT     = 4'd9;

    // Jump conditions.
    typedef logic [2:0] t_cond;
    localparam t_cond COND_NEVER    = 3'd0;
    localparam t_cond COND_ALWAYS   = 3'd1;
    localparam t_cond COND_NO_IN    = 3'd2;
    localparam t_cond COND_ERR      = 3'd3;
    localparam t_cond COND_BUSY     = 3'd4;
    localparam t_cond COND_PASS     = 3'd5;
    localparam t_cond COND_OUT_FULL = 3'd6;

    // Step addresses of the program.
    localparam t_step S_IDLE     = 4'd0;
    localparam t_step S_DIFF     = 4'd1;
    localparam t_step S_MUL      = 4'd2;
    localparam t_step S_DIV_MAP  = 4'd3;
    localparam t_step S_WAIT_MAP = 4'd4;
    localparam t_step S_RES_MAP  = 4'd5;
    localparam t_step S_RD       = 4'd6;
    localparam t_step S_ACC      = 4'd7;
    localparam t_step S_DIV_AVG  = 4'd8;
    localparam t_step S_WAIT_AVG = 4'd9;
    localparam t_step S_RES_AVG  = 4'd10;
    localparam t_step S_OUT_WAIT = 4'd11;
    localparam t_step S_OUT      = 4'd12;
    localparam t_step S_ERR      = 4'd13;

    // One control word per step.
    typedef struct packed {
        logic  take;
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Status that the datapath hands to the sequencer.
    typedef struct packed {
        logic no_in;
        logic err;
        logic busy;
        logic pass;
        logic out_full;
    } t_flags;

    // The control program.
    function automatic t_uword f_urom(input t_step step);
        t_uword w;
        w = '{take: 1'b0, op: OP_NOP, cond: COND_ALWAYS, target: S_IDLE};
        case (step)
            S_IDLE:     w = '{take: 1'b1, op: OP_NOP, cond: COND_NO_IN, target: S_IDLE};
            S_DIFF:     w = '{take: 1'b0, op: OP_DIFF, cond: COND_ERR, target: S_ERR};
            S_MUL:      w = '{take: 1'b0, op: OP_MUL, cond: COND_NEVER, target: S_IDLE};
            S_DIV_MAP:  w = '{take: 1'b0, op: OP_DIV_MAP, cond: COND_NEVER, target: S_IDLE};
            S_WAIT_MAP: w = '{take: 1'b0, op: OP_NOP, cond: COND_BUSY, target: S_WAIT_MAP};
            S_RES_MAP:  w = '{take: 1'b0, op: OP_RES, cond: COND_PASS, target: S_OUT_WAIT};
            S_RD:       w = '{take: 1'b0, op: OP_RD, cond: COND_NEVER, target: S_IDLE};
            S_ACC:      w = '{take: 1'b0, op: OP_ACC, cond: COND_NEVER, target: S_IDLE};
            S_DIV_AVG:  w = '{take: 1'b0, op: OP_DIV_AVG, cond: COND_NEVER, target: S_IDLE};
            S_WAIT_AVG: w = '{take: 1'b0, op: OP_NOP, cond: COND_BUSY, target: S_WAIT_AVG};
            S_RES_AVG:  w = '{take: 1'b0, op: OP_RES, cond: COND_NEVER, target: S_IDLE};
            S_OUT_WAIT: w = '{take: 1'b0, op: OP_NOP, cond: COND_OUT_FULL, target: S_OUT_WAIT};
            S_OUT:      w = '{take: 1'b0, op: OP_OUT, cond: COND_ALWAYS, target: S_IDLE};
            S_ERR:      w = '{take: 1'b0, op: OP_ZERO, cond: COND_ALWAYS, target: S_OUT_WAIT};
            default:    w = '{take: 1'b0, op: OP_NOP, cond: COND_ALWAYS, target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ sv/gaze_map_moving_average.sv @@
// Gaze mapping with moving average: top level with datapath and history store.
//
// Input channel (i_in_valid / o_in_stall): one beat carries the left and right
// pupil positions and the pass_through flag. Output channel (o_out_valid /
// i_out_stall): one beat per input beat with gaze_x, gaze_y and calib_error.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data while the block is idle; the user is bound to this, the block
// does not enforce it. One item is worked on at a time by a microprogrammed
// datapath. Two restoring dividers (x and y side by side) produce one
// quotient bit per cycle over QW = 31 bits at default parameters; they set
// the latency. With pass_through set the result comes from one division;
// otherwise the average costs a second division. A zero span skips both
// divisions. The next input beat is taken in the cycle after the result has
// been placed in the output register.
// Reset clears the history fill count, write slot, running sums and the
// output valid flag, and restores the configuration defaults.
// A stalled result waits in the output register; the datapath finishes the
// following item and then holds it until the output register is free.
module gaze_map_moving_average #(
    parameter int WINDOW     = 10,
    parameter int PUPIL_BITS = 12,
    parameter int FRAC_BITS  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gmma_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gmma_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [gmma_pkg::PIX_W-1:0]          i_left_x,
    input  logic [gmma_pkg::PIX_W-1:0]          i_left_y,
    input  logic [gmma_pkg::PIX_W-1:0]          i_right_x,
    input  logic [gmma_pkg::PIX_W-1:0]          i_right_y,
    input  logic                                i_pass_through,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [gmma_pkg::OUT_W-1:0]   o_gaze_x,
    output logic signed [gmma_pkg::OUT_W-1:0]   o_gaze_y,
    output logic                                o_calib_error
);
    import gmma_pkg::*;

    localparam int PW   = (PUPIL_BITS < PIX_W) ? PUPIL_BITS : PIX_W;
    localparam int DFW  = ((PW + 1 > CAL_W + 1) ? PW + 1 : CAL_W + 1) + 1;
    localparam int PRW  = DFW + SCR_W;
    localparam int NW   = PRW + FRAC_BITS;
    localparam int SLW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FCW  = $clog2(WINDOW + 1);
    localparam int SUMW = OUT_W + $clog2(WINDOW);
    localparam int QW   = (NW > SUMW) ? NW : SUMW;
    localparam int DVW  = (CAL_W + 1 > FCW) ? CAL_W + 1 : FCW;

    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (OUT_W - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Signed, saturated result from a quotient magnitude.
    function automatic logic signed [OUT_W-1:0] f_sat(input logic [QW-1:0] q,
                                                      input logic neg);
        logic signed [OUT_W-1:0] r;
        if (neg) begin
            r = (q > LIM_NEG) ? OUT_MIN : -$signed(q[OUT_W-1:0]);
        end else begin
            r = (q > LIM_POS) ? OUT_MAX : $signed(q[OUT_W-1:0]);
        end
        return r;
    endfunction

    // Configuration registers.
    logic [CAL_W-1:0] r_cal_left, r_cal_top, r_cal_right, r_cal_bottom;
    logic [SCR_W-1:0] r_scr_w, r_scr_h;

    // Sequencer interface.
    t_uword w_uword;
    t_flags w_flags;
    logic   w_accept;

    // Item registers.
    logic [PW-1:0]           r_lx, r_ly, r_rx, r_ry;
    logic                    r_pass;
    logic                    r_err;
    logic signed [DFW-1:0]   r_dx, r_dy;
    logic [CAL_W-1:0]        r_spx, r_spy;
    logic [PRW-1:0]          r_px, r_py;
    logic                    r_negx, r_negy;
    logic signed [OUT_W-1:0] r_gx, r_gy;
    logic signed [OUT_W-1:0] r_oldx, r_oldy;

    // History state.
    logic signed [OUT_W-1:0] r_hist_x [WINDOW];
    logic signed [OUT_W-1:0] r_hist_y [WINDOW];
    logic [FCW-1:0]          r_fill;
    logic [SLW-1:0]          r_slot;
    logic signed [SUMW-1:0]  r_sumx, r_sumy;

    // Output register.
    logic                    r_ovalid;
    logic signed [OUT_W-1:0] r_ox, r_oy;
    logic                    r_oerr;

    // Combinational datapath signals.
    logic                    w_err;
    logic [PW:0]             w_tx, w_ty;
    logic signed [DFW-1:0]   w_dx, w_dy;
    logic [CAL_W-1:0]        w_spx, w_spy;
    logic [DFW-1:0]          w_mx, w_my;
    logic [SUMW-1:0]         w_sax, w_say;
    logic                    w_full;
    logic signed [SUMW-1:0]  w_subx, w_suby;
    logic                    w_div_start;
    logic                    w_avg;
    logic [QW-1:0]           w_numx, w_numy;
    logic [DVW-1:0]          w_denx, w_deny;
    logic                    w_busyx, w_busyy;
    logic [QW-1:0]           w_qx, w_qy;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_left   <= RST_CAL_LEFT;
            r_cal_top    <= RST_CAL_TOP;
            r_cal_right  <= RST_CAL_RIGHT;
            r_cal_bottom <= RST_CAL_BOTTOM;
            r_scr_w      <= RST_SCREEN_WIDTH;
            r_scr_h      <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAL_LEFT:      r_cal_left   <= i_cfg_data[CAL_W-1:0];
                REG_CAL_TOP:       r_cal_top    <= i_cfg_data[CAL_W-1:0];
                REG_CAL_RIGHT:     r_cal_right  <= i_cfg_data[CAL_W-1:0];
                REG_CAL_BOTTOM:    r_cal_bottom <= i_cfg_data[CAL_W-1:0];
                REG_SCREEN_WIDTH:  r_scr_w      <= i_cfg_data[SCR_W-1:0];
                REG_SCREEN_HEIGHT: r_scr_h      <= i_cfg_data[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    gmma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    assign o_in_stall = !w_uword.take;
    assign w_accept   = i_in_valid && w_uword.take;

    always_comb begin
        w_flags.no_in    = !i_in_valid;
        w_flags.err      = w_err;
        w_flags.busy     = w_busyx || w_busyy;
        w_flags.pass     = r_pass;
        w_flags.out_full = r_ovalid && i_out_stall;
    end

    // Offsets from the top-left corner, spans and the zero-span check.
    always_comb begin
        w_err = (r_cal_left == r_cal_right) || (r_cal_top == r_cal_bottom);
        w_tx  = {1'b0, r_lx} + {1'b0, r_rx};
        w_ty  = {1'b0, r_ly} + {1'b0, r_ry};
        w_dx  = $signed(DFW'(w_tx)) - $signed(DFW'({r_cal_left, 1'b0}));
        w_dy  = $signed(DFW'(w_ty)) - $signed(DFW'({r_cal_top, 1'b0}));
        w_spx = (r_cal_right >= r_cal_left) ? r_cal_right - r_cal_left
                                            : r_cal_left - r_cal_right;
        w_spy = (r_cal_bottom >= r_cal_top) ? r_cal_bottom - r_cal_top
                                            : r_cal_top - r_cal_bottom;
        w_mx  = r_dx[DFW-1] ? $unsigned(-r_dx) : $unsigned(r_dx);
        w_my  = r_dy[DFW-1] ? $unsigned(-r_dy) : $unsigned(r_dy);
    end

    // Running-sum update terms.
    always_comb begin
        w_full = (r_fill == FCW'(WINDOW));
        w_subx = w_full ? SUMW'(r_oldx) : '0;
        w_suby = w_full ? SUMW'(r_oldy) : '0;
        w_sax  = r_sumx[SUMW-1] ? $unsigned(-r_sumx) : $unsigned(r_sumx);
        w_say  = r_sumy[SUMW-1] ? $unsigned(-r_sumy) : $unsigned(r_sumy);
    end

    // Divider operands: mapping ratio or running-sum mean.
    always_comb begin
        w_avg       = (w_uword.op == OP_DIV_AVG);
        w_div_start = (w_uword.op == OP_DIV_MAP) || w_avg;
        w_numx      = w_avg ? QW'(w_sax) : (QW'(r_px) << FRAC_BITS);
        w_numy      = w_avg ? QW'(w_say) : (QW'(r_py) << FRAC_BITS);
        w_denx      = w_avg ? DVW'(r_fill) : DVW'({r_spx, 1'b0});
        w_deny      = w_avg ? DVW'(r_fill) : DVW'({r_spy, 1'b0});
    end

    gmma_div #(.NUM_W(QW), .DEN_W(DVW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_numx),
        .i_den   (w_denx),
        .o_busy  (w_busyx),
        .o_quo   (w_qx)
    );

    gmma_div #(.NUM_W(QW), .DEN_W(DVW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_numy),
        .i_den   (w_deny),
        .o_busy  (w_busyy),
        .o_quo   (w_qy)
    );

    // Item datapath registers, driven by the current control word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lx   <= i_left_x[PW-1:0];
            r_ly   <= i_left_y[PW-1:0];
            r_rx   <= i_right_x[PW-1:0];
            r_ry   <= i_right_y[PW-1:0];
            r_pass <= i_pass_through;
        end
        case (w_uword.op)
            OP_DIFF: begin
                r_dx  <= w_dx;
                r_dy  <= w_dy;
                r_spx <= w_spx;
                r_spy <= w_spy;
                r_err <= w_err;
            end
            OP_MUL: begin
                r_px   <= PRW'(w_mx) * PRW'(r_scr_w);
                r_py   <= PRW'(w_my) * PRW'(r_scr_h);
                r_negx <= r_dx[DFW-1];
                r_negy <= r_dy[DFW-1];
            end
            OP_DIV_AVG: begin
                r_negx <= r_sumx[SUMW-1];
                r_negy <= r_sumy[SUMW-1];
            end
            OP_RES: begin
                r_gx <= f_sat(w_qx, r_negx);
                r_gy <= f_sat(w_qy, r_negy);
            end
            OP_ZERO: begin
                r_gx <= '0;
                r_gy <= '0;
            end
            default: ;
        endcase
    end

    // History store: read the evicted entry, then overwrite it.
    always_ff @(posedge i_clk) begin
        if (w_uword.op == OP_RD) begin
            r_oldx <= r_hist_x[r_slot];
            r_oldy <= r_hist_y[r_slot];
        end
        if (w_uword.op == OP_ACC) begin
            r_hist_x[r_slot] <= r_gx;
            r_hist_y[r_slot] <= r_gy;
        end
    end

    // Fill count, write slot and running sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_slot <= '0;
            r_sumx <= '0;
            r_sumy <= '0;
        end else if (w_uword.op == OP_ACC) begin
            r_sumx <= r_sumx - w_subx + SUMW'(r_gx);
            r_sumy <= r_sumy - w_suby + SUMW'(r_gy);
            if (!w_full) begin
                r_fill <= r_fill + 1'b1;
            end
            r_slot <= (r_slot == SLW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_uword.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uword.op == OP_OUT) begin
            r_ox   <= r_gx;
            r_oy   <= r_gy;
            r_oerr <= r_err;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_gaze_x      = r_ox;
    assign o_gaze_y      = r_oy;
    assign o_calib_error = r_oerr;

endmodule

@@ sv/gmma_div.sv @@
// Restoring unsigned divider that produces one quotient bit per cycle.
module gmma_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = !w_diff[DEN_W];
    end

    // Control: count the iterations of one division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

@@ sv/gmma_seq.sv @@
// Microprogram sequencer: step counter, control store and conditional jumps.
module gmma_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gmma_pkg::t_flags i_flags,
    output gmma_pkg::t_uword o_uword
);
    import gmma_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_jump;

    // Fetch the control word of the current step.
    assign w_uword = f_urom(r_step);

    // Evaluate the jump condition.
    always_comb begin
        case (w_uword.cond)
            COND_NEVER:    w_jump = 1'b0;
            COND_ALWAYS:   w_jump = 1'b1;
            COND_NO_IN:    w_jump = i_flags.no_in;
            COND_ERR:      w_jump = i_flags.err;
            COND_BUSY:     w_jump = i_flags.busy;
            COND_PASS:     w_jump = i_flags.pass;
            COND_OUT_FULL: w_jump = i_flags.out_full;
            default:       w_jump = 1'b1;
        endcase
        n_step = w_jump ? w_uword.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = w_uword;

endmodule

@@ sv/gmma_chk.sv @@
// Port-level checker for the gaze mapping block and its bind statement.
module gmma_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [gmma_pkg::OUT_W-1:0]   o_gaze_x,
    input logic signed [gmma_pkg::OUT_W-1:0]   o_gaze_y,
    input logic                                o_calib_error
);

    // A stalled result beat stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_gaze_x) && $stable(o_gaze_y) && $stable(o_calib_error)))
        else $error("result payload changed while stalled");

    // A calibration error always reports the origin.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_calib_error) |-> (o_gaze_x == '0 && o_gaze_y == '0))
        else $error("calibration error with nonzero gaze");

    // Once a beat is taken, the block is busy with it in the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second input beat taken while an item is in flight");

endmodule

bind gaze_map_moving_average gmma_chk u_gmma_chk (.*);

@@ dv/gaze_map_moving_average_tb.sv @@
// Self-checking testbench for the gaze mapping block with moving average.
module tb;
    import gmma_pkg::*;

    localparam int WINDOW      = 10;
    localparam int FRAC_BITS   = 4;
    localparam longint OUT_MIN = -64'sd1048576;
    localparam longint OUT_MAX = 64'sd1048575;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 74;
    localparam int EXP_DEPTH   = 8;

    // One input beat: both pupil positions and the pass-through flag.
    typedef struct packed {
        logic [PIX_W-1:0] left_x;
        logic [PIX_W-1:0] left_y;
        logic [PIX_W-1:0] right_x;
        logic [PIX_W-1:0] right_y;
        logic             pass_through;
    } t_pupil_beat;

    // One output beat.
    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    err;
    } t_gaze;

    // Calibration and screen registers.
    typedef struct packed {
        logic [CAL_W-1:0] left;
        logic [CAL_W-1:0] top;
        logic [CAL_W-1:0] right;
        logic [CAL_W-1:0] bottom;
        logic [SCR_W-1:0] width;
        logic [SCR_W-1:0] height;
    } t_cal_regs;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_left_x       = '0;
    logic [PIX_W-1:0]     i_left_y       = '0;
    logic [PIX_W-1:0]     i_right_x      = '0;
    logic [PIX_W-1:0]     i_right_y      = '0;
    logic                 i_pass_through = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic signed [OUT_W-1:0] o_gaze_x;
    logic signed [OUT_W-1:0] o_gaze_y;
    logic                 o_calib_error;

    // Predictor state: calibration, gaze history ring and running sums.
    t_cal_regs cal;
    longint    ring_x [WINDOW];
    longint    ring_y [WINDOW];
    int        ring_fill;
    int        ring_slot;
    longint    ring_sum_x;
    longint    ring_sum_y;

    // Expected gaze points in order; written by the sender, read by the checker.
    t_gaze expected_gaze [EXP_DEPTH];
    int    exp_wr         = 0;
    int    exp_rd         = 0;
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    int    send_idle_pct  = 0;
    int    recv_idle_pct  = 0;
    logic  hold_req       = 1'b0;
    logic  hold_seen      = 1'b0;
    int    hold_left      = 0;

    gaze_map_moving_average i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_x       (i_left_x),
        .i_left_y       (i_left_y),
        .i_right_x      (i_right_x),
        .i_right_y      (i_right_y),
        .i_pass_through (i_pass_through),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_gaze_x       (o_gaze_x),
        .o_gaze_y       (o_gaze_y),
        .o_calib_error  (o_calib_error)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL gaze_map_moving_average");
            $finish;
        end
    end

    // Receiver back-pressure: random stalls, or a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Append one expected gaze point.
    task automatic store_expected(input t_gaze g);
        if (exp_wr - exp_rd >= EXP_DEPTH)
            report_mismatch("more beats in flight than the block can hold");
        expected_gaze[exp_wr % EXP_DEPTH] = g;
        exp_wr++;
    endtask

    // Compare every accepted output beat with the oldest expected gaze point.
    always @(posedge i_clk) begin
        t_gaze want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("output beat with no expected gaze point");
            end else begin
                want = expected_gaze[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_gaze_x !== want.x)
                    report_mismatch($sformatf("gaze_x %0d, expected %0d", o_gaze_x, want.x));
                if (o_gaze_y !== want.y)
                    report_mismatch($sformatf("gaze_y %0d, expected %0d", o_gaze_y, want.y));
                if (o_calib_error !== want.err)
                    report_mismatch($sformatf("calib_error %0b, expected %0b",
                                              o_calib_error, want.err));
            end
        end
    end

    function automatic void reset_model();
        cal = '{left: RST_CAL_LEFT, top: RST_CAL_TOP, right: RST_CAL_RIGHT,
                bottom: RST_CAL_BOTTOM, width: RST_SCREEN_WIDTH,
                height: RST_SCREEN_HEIGHT};
        ring_fill  = 0;
        ring_slot  = 0;
        ring_sum_x = 0;
        ring_sum_y = 0;
    endfunction

    // Linear map of the pupil midpoint onto one screen axis, truncated and saturated.
    function automatic longint map_to_screen(input longint a, input longint b,
                                             input longint origin, input longint far_end,
                                             input longint size);
        longint diff;
        longint span;
        longint q;
        diff = a + b - 2 * origin;
        span = far_end - origin;
        if (span < 0)
            span = -span;
        q = (diff * size * (64'sd1 << FRAC_BITS)) / (2 * span);
        if (q < OUT_MIN)
            q = OUT_MIN;
        if (q > OUT_MAX)
            q = OUT_MAX;
        return q;
    endfunction

    // Expected output for one accepted beat; updates the history unless it is passed through or flagged.
    function automatic t_gaze predict_gaze(input t_pupil_beat b);
        t_gaze  g;
        longint gx;
        longint gy;
        g = '0;
        // A collapsed calibration box flags an error and leaves history alone.
        if (cal.left == cal.right || cal.top == cal.bottom) begin
            g.err = 1'b1;
            return g;
        end
        gx = map_to_screen(b.left_x, b.right_x, cal.left, cal.right, cal.width);
        gy = map_to_screen(b.left_y, b.right_y, cal.top, cal.bottom, cal.height);
        if (!b.pass_through) begin
            if (ring_fill >= WINDOW) begin
                ring_sum_x -= ring_x[ring_slot];
                ring_sum_y -= ring_y[ring_slot];
            end else begin
                ring_fill++;
            end
            ring_x[ring_slot] = gx;
            ring_y[ring_slot] = gy;
            ring_sum_x += gx;
            ring_sum_y += gy;
            ring_slot = (ring_slot + 1) % WINDOW;
            gx = ring_sum_x / ring_fill;
            gy = ring_sum_y / ring_fill;
        end
        g.x = gx[OUT_W-1:0];
        g.y = gy[OUT_W-1:0];
        return g;
    endfunction

    // Offer one beat after a random gap; valid stays high for a following beat.
    task automatic send_gaze(input t_pupil_beat b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_left_x       <= b.left_x;
        i_left_y       <= b.left_y;
        i_right_x      <= b.right_x;
        i_right_y      <= b.right_y;
        i_pass_through <= b.pass_through;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        store_expected(predict_gaze(b));
    endtask

    // Stop offering beats and wait for every expected gaze point.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write all six registers back to back; the block must be idle.
    task automatic program_calibration(input t_cal_regs c);
        write_reg(REG_CAL_LEFT, CFG_W'(c.left));
        write_reg(REG_CAL_TOP, CFG_W'(c.top));
        write_reg(REG_CAL_RIGHT, CFG_W'(c.right));
        write_reg(REG_CAL_BOTTOM, CFG_W'(c.bottom));
        write_reg(REG_SCREEN_WIDTH, c.width);
        write_reg(REG_SCREEN_HEIGHT, c.height);
        i_cfg_we <= 1'b0;
        cal = c;
    endtask

    function automatic t_pupil_beat make_beat(input int lx, input int ly, input int rx,
                                              input int ry, input bit pass);
        t_pupil_beat b;
        b = '{left_x: lx[PIX_W-1:0], left_y: ly[PIX_W-1:0], right_x: rx[PIX_W-1:0],
              right_y: ry[PIX_W-1:0], pass_through: pass};
        return b;
    endfunction

    function automatic logic [SCR_W-1:0] random_screen_size();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'd8191;
            default: return SCR_W'($urandom_range(1, 8191));
        endcase
    endfunction

    // Mostly sane calibration boxes, with reversed, collapsed and wild ones mixed in.
    function automatic t_cal_regs random_calibration();
        t_cal_regs c;
        int        pick;
        c.left   = CAL_W'($urandom_range(0, 3000));
        c.top    = CAL_W'($urandom_range(0, 3000));
        c.right  = c.left + CAL_W'($urandom_range(1, 1095));
        c.bottom = c.top + CAL_W'($urandom_range(1, 1095));
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
            c.right = c.left;
        end else if (pick == 1) begin
            c.bottom = c.top;
        end else if (pick <= 3) begin
            {c.left, c.right} = {c.right, c.left};
            {c.top, c.bottom} = {c.bottom, c.top};
        end else if (pick == 4) begin
            c.left   = CAL_W'($urandom);
            c.top    = CAL_W'($urandom);
            c.right  = CAL_W'($urandom);
            c.bottom = CAL_W'($urandom);
        end
        c.width  = random_screen_size();
        c.height = random_screen_size();
        return c;
    endfunction

    // Pupils mostly inside the calibration box, sometimes anywhere on the sensor.
    function automatic t_pupil_beat random_pupils(input t_cal_regs c);
        t_pupil_beat b;
        int          lo_x;
        int          hi_x;
        int          lo_y;
        int          hi_y;
        lo_x = (c.left < c.right) ? c.left : c.right;
        hi_x = (c.left < c.right) ? c.right : c.left;
        lo_y = (c.top < c.bottom) ? c.top : c.bottom;
        hi_y = (c.top < c.bottom) ? c.bottom : c.top;
        if ($urandom_range(0, 3) == 0) begin
            b = make_beat($urandom, $urandom, $urandom, $urandom, 1'b0);
        end else begin
            b = make_beat($urandom_range(lo_x, hi_x), $urandom_range(lo_y, hi_y),
                          $urandom_range(lo_x, hi_x), $urandom_range(lo_y, hi_y), 1'b0);
        end
        b.pass_through = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    // Reset calibration: both field extremes and alternating bit patterns.
    task automatic test_reset_defaults();
        send_gaze(make_beat(0, 0, 0, 0, 1'b0));
        send_gaze(make_beat(4095, 4095, 4095, 4095, 1'b0));
        send_gaze(make_beat(0, 0, 0, 0, 1'b1));
        send_gaze(make_beat(4095, 4095, 4095, 4095, 1'b1));
        send_gaze(make_beat('hAAA, 'h555, 'h555, 'hAAA, 1'b0));
        send_gaze(make_beat('h555, 'hAAA, 'hAAA, 'h555, 1'b1));
        wait_results_drained();
    endtask

    // Saturation, reversed corners, collapsed spans and zero screen sizes.
    task automatic test_corner_calibrations();
        // A one-pixel span drives the mapping far out of range both ways.
        program_calibration('{left: 2000, top: 2000, right: 2001, bottom: 2001,
                              width: 8191, height: 8191});
        send_gaze(make_beat(4095, 4095, 4095, 4095, 1'b1));
        send_gaze(make_beat(0, 0, 0, 0, 1'b1));
        send_gaze(make_beat(4095, 0, 4095, 0, 1'b0));
        send_gaze(make_beat(0, 4095, 0, 4095, 1'b0));
        wait_results_drained();
        // Bottom-right corner above and left of the top-left corner.
        program_calibration('{left: 4095, top: 4095, right: 0, bottom: 0,
                              width: 8191, height: 8191});
        send_gaze(make_beat(0, 0, 0, 0, 1'b0));
        send_gaze(make_beat(4095, 4095, 4095, 4095, 1'b0));
        send_gaze(make_beat(100, 3000, 200, 3100, 1'b1));
        wait_results_drained();
        // Zero width span.
        program_calibration('{left: 100, top: 50, right: 100, bottom: 400,
                              width: 1920, height: 1080});
        send_gaze(make_beat(300, 300, 310, 310, 1'b0));
        send_gaze(make_beat(300, 300, 310, 310, 1'b1));
        wait_results_drained();
        // Zero height span.
        program_calibration('{left: 100, top: 400, right: 700, bottom: 400,
                              width: 1920, height: 1080});
        send_gaze(make_beat(300, 300, 310, 310, 1'b0));
        send_gaze(make_beat(300, 300, 310, 310, 1'b1));
        wait_results_drained();
        // Zero screen size maps every point to the origin.
        program_calibration('{left: 10, top: 20, right: 630, bottom: 470,
                              width: 0, height: 0});
        send_gaze(make_beat(4095, 4095, 4095, 4095, 1'b0));
        send_gaze(make_beat(0, 0, 0, 0, 1'b1));
        wait_results_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering beats.
    task automatic test_output_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_calibration('{left: 40, top: 30, right: 600, bottom: 450,
                              width: 1920, height: 1080});
        hold_req <= ~hold_req;
        repeat (24)
            send_gaze(random_pupils(cal));
        wait_results_drained();
    endtask

    // Random traffic over several calibrations at one idling setting.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (PHASES) begin
            wait_results_drained();
            program_calibration(random_calibration());
            repeat (PHASE_BEATS) begin
                // Now and then the sender waits for the pipeline to empty.
                if ($urandom_range(0, 49) == 0)
                    wait_results_drained();
                send_gaze(random_pupils(cal));
            end
        end
    endtask

    // Test sequence.
    initial begin
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_corner_calibrations();
        test_output_holdoff();
        test_random_traffic(20, 47);
        test_random_traffic(47, 20);
        test_random_traffic(0, 0);
        wait_results_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && exp_wr == exp_rd)
            $display("PASS gaze_map_moving_average");
        else
            $display("FAIL gaze_map_moving_average");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/gmma_pkg.sv
sv/gmma_div.sv
sv/gmma_seq.sv
sv/gaze_map_moving_average.sv
sv/gmma_chk.sv
dv/gaze_map_moving_average_tb.sv
